/* hw/rtl/rpc_pkg.sv */
// rpc_pkg: shared types and constants for the rgb565 pixel compositor
// no dependencies; imported by the compositor top level and its checker

package rpc_pkg;

  // blend mode register codes
  typedef enum logic [1:0] {
    MODE_OPAQUE = 2'd0,
    MODE_KEY    = 2'd1,
    MODE_BLEND  = 2'd2,
    MODE_SPARE  = 2'd3
  } blend_mode_e;

  // configuration register indexes
  localparam logic CFG_BLEND_MODE = 1'b0;
  localparam logic CFG_KEY_COLOR  = 1'b1;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned PROD_W  = 14;  // 6-bit channel times 8-bit alpha
  localparam int unsigned LAT     = 3;   // register stages from input to output

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'hFF;

  // one product pair per color channel: index 0 blue, 1 green, 2 red
  typedef logic [2:0][PROD_W-1:0] chan_vec_t;

endpackage

/* hw/rtl/rgb565_pixel_compositor_unit.sv */
// rgb565_pixel_compositor_unit: three-stage opaque / color-key / alpha-blend pixel pipeline
// depends on rpc_pkg
//
//  channel      | direction | payload (low bits first)                | transaction
//  -------------+-----------+-----------------------------------------+-------------------
//  s_axis       | in        | tdata: src_pixel, dst_pixel, alpha      | tvalid & tready
//  m_axis       | out       | tdata: out_pixel; tuser: write_enable   | tvalid & tready
//  cfg          | in        | addr 0 blend_mode, addr 1 key_color     | cfg_we_i high
//
//  one pixel per clock sustained while m_axis does not stall; an accepted pixel passes
//  through the multiply and channel sum registers into the output register (divide/pack)
//  reset clears the stage valid bits and the config registers (opaque mode, key 0)
//  a stall at m_axis holds the output register; a stage only loads when the stage
//  below it is empty or moving, so bubbles are squeezed out and nothing is repeated

module rgb565_pixel_compositor_unit
  import rpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [PIX_W-1:0]    cfg_wdata_i,
  // pixel input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [39:0]         s_axis_tdata_i,   // [15:0] src_pixel, [31:16] dst_pixel,
                                                // [39:32] alpha
  // pixel output stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [PIX_W-1:0]    m_axis_tdata_o,   // [15:0] out_pixel
  output logic                m_axis_tuser_o    // [0] write_enable
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  blend_mode_e          blend_mode_q;
  logic [PIX_W-1:0]     key_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= MODE_OPAQUE;
      key_color_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_BLEND_MODE: blend_mode_q <= blend_mode_e'(cfg_wdata_i[1:0]);
        CFG_KEY_COLOR:  key_color_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: a stage advances when the stage after it is empty or advancing
  // ---------------------------------------------------------------------------
  logic valid_a_q, valid_b_q, valid_c_q;
  logic adv_a, adv_b, adv_c;

  assign adv_c = !valid_c_q || m_axis_tready_i;
  assign adv_b = !valid_b_q || adv_c;
  assign adv_a = !valid_a_q || adv_b;
  assign s_axis_tready_o = adv_a;

  logic in_fire;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      if (adv_a) valid_a_q <= in_fire;
      if (adv_b) valid_b_q <= valid_a_q;
      if (adv_c) valid_c_q <= valid_b_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: mode decision and channel products
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]   src_pix, dst_pix, src_uns, dst_uns;
  logic [ALPHA_W-1:0] alpha, alpha_inv;

  assign src_pix   = s_axis_tdata_i[15:0];
  assign dst_pix   = s_axis_tdata_i[31:16];
  assign alpha     = s_axis_tdata_i[39:32];
  assign alpha_inv = ALPHA_MAX - alpha;

  // undo the byte swap so the channels are contiguous
  assign src_uns = {src_pix[7:0], src_pix[15:8]};
  assign dst_uns = {dst_pix[7:0], dst_pix[15:8]};

  // zero-extended channel values: blue, green, red
  logic [2:0][5:0] src_ch, dst_ch;
  assign src_ch[0] = {1'b0, src_uns[4:0]};
  assign src_ch[1] = src_uns[10:5];
  assign src_ch[2] = {1'b0, src_uns[15:11]};
  assign dst_ch[0] = {1'b0, dst_uns[4:0]};
  assign dst_ch[1] = dst_uns[10:5];
  assign dst_ch[2] = {1'b0, dst_uns[15:11]};

  // copy / keep / blend decision; blend_d marks the pixels that need the divide
  logic [PIX_W-1:0] base_pix_d;
  logic             we_d, blend_d;

  always_comb begin
    base_pix_d = dst_pix;
    we_d       = 1'b0;
    blend_d    = 1'b0;
    case (blend_mode_q)
      MODE_OPAQUE: begin
        base_pix_d = src_pix;
        we_d       = 1'b1;
      end
      MODE_KEY: begin
        if (src_pix != key_color_q) begin
          base_pix_d = src_pix;
          we_d       = 1'b1;
        end
      end
      default: begin
        // blend mode; the spare code behaves the same way
        if (alpha == ALPHA_MAX) begin
          base_pix_d = src_pix;
          we_d       = 1'b1;
        end else if (alpha != '0) begin
          we_d    = 1'b1;
          blend_d = 1'b1;
        end
      end
    endcase
  end

  chan_vec_t        prod_s_a_q, prod_d_a_q;
  logic [PIX_W-1:0] base_pix_a_q;
  logic             we_a_q, blend_a_q;

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      for (int c = 0; c < 3; c++) begin
        prod_s_a_q[c] <= PROD_W'(src_ch[c]) * PROD_W'(alpha);
        prod_d_a_q[c] <= PROD_W'(dst_ch[c]) * PROD_W'(alpha_inv);
      end
      base_pix_a_q <= base_pix_d;
      we_a_q       <= we_d;
      blend_a_q    <= blend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: weighted channel sums, at most 63 * 255 so 14 bits hold them
  // ---------------------------------------------------------------------------
  chan_vec_t        sum_b_q;
  logic [PIX_W-1:0] base_pix_b_q;
  logic             we_b_q, blend_b_q;

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      for (int c = 0; c < 3; c++) begin
        sum_b_q[c] <= prod_s_a_q[c] + prod_d_a_q[c];
      end
      base_pix_b_q <= base_pix_a_q;
      we_b_q       <= we_a_q;
      blend_b_q    <= blend_a_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: divide by 255, pack, swap bytes back, output register
  // x / 255 == (x + 1 + (x >> 8)) >> 8 for every x below 65535
  // ---------------------------------------------------------------------------
  logic [2:0][PROD_W:0] quot_full;
  logic [PIX_W-1:0]     mix_uns, mix_pix;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quot_full[c] = {1'b0, sum_b_q[c]} + (PROD_W+1)'(1)
                   + {{(PROD_W-5){1'b0}}, sum_b_q[c][PROD_W-1:8]};
    end
  end

  assign mix_uns = {quot_full[2][12:8], quot_full[1][13:8], quot_full[0][12:8]};
  assign mix_pix = {mix_uns[7:0], mix_uns[15:8]};

  logic [PIX_W-1:0] out_pix_q;
  logic             out_we_q;

  always_ff @(posedge clk_i) begin
    if (adv_c) begin
      out_pix_q <= blend_b_q ? mix_pix : base_pix_b_q;
      out_we_q  <= we_b_q;
    end
  end

  assign m_axis_tvalid_o = valid_c_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tuser_o  = out_we_q;

endmodule

/* hw/rtl/rpc_checker.sv */
// rpc_checker: port-level assertions for the rgb565 pixel compositor
// depends on rpc_pkg; bound to rgb565_pixel_compositor_unit at the end of this file

module rpc_checker
  import rpc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [PIX_W-1:0] m_axis_tdata_o,
  input logic             m_axis_tuser_o
);

  logic in_fire;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output payload changed under stall");

  // the pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  // an accepted pixel reaches the output after the pipeline depth when not stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire ##1 m_axis_tready_i ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("accepted pixel did not reach the output in time");

  // with an empty, unstalled output the input side cannot be blocked
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output side is ready");

endmodule

bind rgb565_pixel_compositor_unit rpc_checker u_rpc_checker (.*);
